### hw/rtl/alist_pkg.sv
// Shared types, sizes and codes for the array list engine.
package alist_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Field widths on the stream ports
    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int LOC_W   = 7;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;

    // Common width for comparing a request index against the count
    localparam int CMP_W = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    typedef enum logic [REQ_W-1:0] {
        OP_APPEND = 3'd0,
        OP_SEARCH = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [LOC_W-1:0]         location;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] data;
    } rsp_t;

endpackage

### hw/rtl/alist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/alist_ctrl.sv
// Request sequencer: walks the list store one word per cycle, read-modify-write.
module alist_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  alist_pkg::req_t      req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output alist_pkg::rsp_t      rsp
);
    import alist_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [REQ_W-1:0]  op_reg, op_next;
    word_t             word_reg, word_next;
    count_t            pos_reg, pos_next;
    count_t            cnt_reg, cnt_next;
    count_t            addr_reg, addr_next;
    count_t            rem_reg, rem_next;
    count_t            kept_reg, kept_next;
    logic              pend_reg, pend_next;
    count_t            pend_addr_reg, pend_addr_next;
    status_t           stat_reg, stat_next;
    logic [LOC_W-1:0]  loc_reg, loc_next;
    word_t             data_reg, data_next;

    logic              ram_we;
    addr_t             ram_waddr;
    word_t             ram_wdata;
    logic              ram_re;
    addr_t             ram_raddr;
    word_t             ram_rdata;

    logic              accept;
    word_t             in_word;
    logic [CMP_W-1:0]  in_pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              full;
    count_t            ins_addr;
    count_t            loc_cnt;

    alist_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = (state_reg == S_RESP);
    assign in_word   = WORD_WIDTH'(req.value);
    assign in_pos_x  = CMP_W'(req.position);
    assign cnt_x     = CMP_W'(cnt_reg);
    assign full      = (cnt_reg >= count_t'(DEPTH));
    assign ins_addr  = pend_addr_reg + count_t'(1);
    assign loc_cnt   = pend_addr_reg + count_t'(1);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        kept_next      = kept_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        stat_next      = stat_reg;
        loc_next       = loc_reg;
        data_next      = data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = in_word;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next   = req.req_type;
                    word_next = in_word;
                    pos_next  = count_t'(req.position);
                    stat_next = ST_OK;
                    loc_next  = '0;
                    data_next = '0;
                    addr_next = '0;
                    rem_next  = cnt_reg;
                    kept_next = '0;
                    case (req.req_type)
                        OP_APPEND: begin
                            if (full) begin
                                stat_next = ST_FULL;
                            end else begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + count_t'(1);
                            end
                            state_next = S_RESP;
                        end
                        OP_SEARCH, OP_DELETE: begin
                            state_next = S_WALK;
                        end
                        OP_INSERT: begin
                            if (in_pos_x > cnt_x) begin
                                stat_next  = ST_BAD_INDEX;
                                state_next = S_RESP;
                            end else if (full) begin
                                stat_next  = ST_FULL;
                                state_next = S_RESP;
                            end else begin
                                // tail moves top-down so no source is overwritten early
                                addr_next  = cnt_reg - count_t'(1);
                                rem_next   = cnt_reg - count_t'(req.position);
                                state_next = S_WALK;
                            end
                        end
                        OP_READ: begin
                            if (in_pos_x >= cnt_x) begin
                                stat_next  = ST_BAD_INDEX;
                                state_next = S_RESP;
                            end else begin
                                addr_next  = count_t'(req.position);
                                rem_next   = count_t'(1);
                                state_next = S_WALK;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // issue the next read
                if (rem_reg != '0) begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                    rem_next       = rem_reg - count_t'(1);
                    if (op_reg == OP_INSERT) begin
                        addr_next = addr_reg - count_t'(1);
                    end else begin
                        addr_next = addr_reg + count_t'(1);
                    end
                end

                // consume the word read last cycle
                if (pend_reg) begin
                    case (op_reg)
                        OP_SEARCH: begin
                            if (ram_rdata == word_reg) begin
                                loc_next   = LOC_W'(loc_cnt);
                                state_next = S_RESP;
                            end
                        end
                        OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = ins_addr[ADDR_W-1:0];
                            ram_wdata = ram_rdata;
                        end
                        OP_DELETE: begin
                            // kept never passes the read pointer
                            if (ram_rdata != word_reg) begin
                                ram_we    = 1'b1;
                                ram_waddr = kept_reg[ADDR_W-1:0];
                                ram_wdata = ram_rdata;
                                kept_next = kept_reg + count_t'(1);
                            end
                        end
                        OP_READ: begin
                            data_next  = ram_rdata;
                            state_next = S_RESP;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end else if (rem_reg == '0) begin
                    case (op_reg)
                        OP_SEARCH: begin
                            stat_next = ST_NOT_FOUND;
                        end
                        OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg[ADDR_W-1:0];
                            ram_wdata = word_reg;
                            cnt_next  = cnt_reg + count_t'(1);
                        end
                        OP_DELETE: begin
                            if (kept_reg == cnt_reg) begin
                                stat_next = ST_NOT_FOUND;
                            end
                            cnt_next = kept_reg;
                        end
                        default: begin
                        end
                    endcase
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
        op_reg        <= op_next;
        word_reg      <= word_next;
        pos_reg       <= pos_next;
        addr_reg      <= addr_next;
        rem_reg       <= rem_next;
        kept_reg      <= kept_next;
        pend_addr_reg <= pend_addr_next;
        stat_reg      <= stat_next;
        loc_reg       <= loc_next;
        data_reg      <= data_next;
    end

    assign rsp.status   = stat_reg;
    assign rsp.location = loc_reg;
    assign rsp.count    = CNT_W'(cnt_reg);
    assign rsp.data     = DATA_W'(data_reg);

endmodule

### hw/rtl/array_list_engine.sv
// Top level of the array list engine: stream ports, result register, checks.
//
// Keeps a packed list of up to 64 signed 32-bit words plus a count, in one
// synchronous RAM. Each input word is one request: append, search, insert at
// index, delete by value, or read at index; each request yields exactly one
// result word carrying status, 1-based match location, the count after the
// request and the word read. Append, rejected requests and unused request
// codes go from the accept straight to the result state, then through the
// output register to m_tvalid. Search, insert, delete and read walk the RAM
// with one access per cycle through its single read port. Insert walks from
// the end down to the index, delete and search from the start. One request
// is in work at a time; a finished result sits in the output register so
// the next request is taken while it waits for m_tready. No clearing pass
// is needed after reset: only entries below the count are ever read.
module array_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [6:0] location, [13:7] count, [45:14] data, [47:46] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import alist_pkg::*;

    req_t        req;
    rsp_t        rsp;
    logic        rsp_valid;
    logic        rsp_ready;

    logic        m_tvalid_reg, m_tvalid_next;
    rsp_t        m_rsp_reg, m_rsp_next;

    assign req.req_type = s_tuser;
    assign req.value    = s_tdata[31:0];
    assign req.position = s_tdata[38:32];

    alist_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // result register: free when empty or being drained this cycle
    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_rsp_next    = m_rsp_reg;
        if (rsp_ready) begin
            m_tvalid_next = rsp_valid;
            if (rsp_valid) begin
                m_rsp_next = rsp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_rsp_reg <= m_rsp_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_rsp_reg.status;
    assign m_tdata  = {2'b00, m_rsp_reg.data, m_rsp_reg.count, m_rsp_reg.location};

    // reported count never exceeds the list capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:7] <= CNT_W'(DEPTH)))
        else $error("result count above capacity");

    // a match location lies inside the list
    a_loc_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:0] != '0) |-> (m_tdata[6:0] <= m_tdata[13:7]))
        else $error("match location beyond count");

    // one request in work at a time: accept closes the input for the next cycle
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // a location is reported only with an ok status
    a_loc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:0] != '0) |-> (m_tuser == ST_OK))
        else $error("location with failing status");

endmodule
